@@ rtl/rlp_pkg.sv @@
package rlp_pkg;

   // Default geometry of the result and of the fraction store.
   localparam int DEF_INT_BITS        = 32;
   localparam int DEF_FRAC_BITS       = 32;
   localparam int DEF_MAX_FRAC_DIGITS = 16;

   localparam int COUNT_W = 5;   // holds a fraction digit count of up to 16
   localparam int NUM_W   = 64;  // fraction numerator
   localparam int DEN_W   = 65;  // radix power, up to 2^64

   localparam logic [4:0] RADIX_NONE = 5'd0;
   localparam logic [4:0] RADIX_BIN  = 5'd2;
   localparam logic [4:0] RADIX_OCT  = 5'd8;
   localparam logic [4:0] RADIX_DEC  = 5'd10;
   localparam logic [4:0] RADIX_HEX  = 5'd16;

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_BAD_BIN    = 3'd1;
   localparam logic [2:0] ST_BAD_HEX    = 3'd2;
   localparam logic [2:0] ST_BAD_OCT    = 3'd3;
   localparam logic [2:0] ST_BAD_DEC    = 3'd4;
   localparam logic [2:0] ST_BAD_PREFIX = 3'd5;
   localparam logic [2:0] ST_SATURATED  = 3'd6;

   localparam logic [7:0] CHAR_0     = 8'h30;
   localparam logic [7:0] CHAR_1     = 8'h31;
   localparam logic [7:0] CHAR_7     = 8'h37;
   localparam logic [7:0] CHAR_9     = 8'h39;
   localparam logic [7:0] CHAR_A     = 8'h41;
   localparam logic [7:0] CHAR_F     = 8'h46;
   localparam logic [7:0] CHAR_B_UP  = 8'h42;
   localparam logic [7:0] CHAR_B_LO  = 8'h62;
   localparam logic [7:0] CHAR_X_UP  = 8'h58;
   localparam logic [7:0] CHAR_X_LO  = 8'h78;
   localparam logic [7:0] CHAR_POINT = 8'h2E;
   localparam logic [7:0] HEX_LETTER_OFFSET = 8'd55;

   typedef struct packed {
      logic [7:0] character;
      logic       end_of_literal;
   } rlp_req_type;

   typedef struct packed {
      logic [63:0] value;
      logic [2:0]  status;
   } rlp_rsp_type;

   // What the scanner hands over when a literal closes.
   typedef struct packed {
      logic [4:0]         radix;
      logic [COUNT_W-1:0] frac_count;
      logic [2:0]         status;
   } rlp_summary_type;

   // Returns {valid, digit value} of a character in the given radix.
   function automatic logic [4:0] digit_of(input logic [7:0] c, input logic [4:0] radix);
      logic       ok;
      logic [7:0] d;
      ok = 1'b0;
      d  = c - CHAR_0;
      case (radix)
         RADIX_HEX: begin
            if (c inside {[CHAR_0:CHAR_9]}) begin
               ok = 1'b1;
            end else if (c inside {[CHAR_A:CHAR_F]}) begin
               ok = 1'b1;
               d  = c - HEX_LETTER_OFFSET;
            end
         end
         RADIX_DEC: ok = (c inside {[CHAR_0:CHAR_9]});
         RADIX_OCT: ok = (c inside {[CHAR_0:CHAR_7]});
         RADIX_BIN: ok = (c inside {[CHAR_0:CHAR_1]});
         default:   ok = 1'b0;
      endcase
      return {ok, d[3:0]};
   endfunction

   function automatic logic [2:0] bad_code(input logic [4:0] radix);
      logic [2:0] code;
      case (radix)
         RADIX_BIN: code = ST_BAD_BIN;
         RADIX_HEX: code = ST_BAD_HEX;
         RADIX_OCT: code = ST_BAD_OCT;
         default:   code = ST_BAD_DEC;
      endcase
      return code;
   endfunction

   function automatic logic [DEN_W-1:0] pow10(input logic [COUNT_W-1:0] n);
      logic [DEN_W-1:0] p;
      case (n)
         5'd0:    p = 65'd1;
         5'd1:    p = 65'd10;
         5'd2:    p = 65'd100;
         5'd3:    p = 65'd1000;
         5'd4:    p = 65'd10000;
         5'd5:    p = 65'd100000;
         5'd6:    p = 65'd1000000;
         5'd7:    p = 65'd10000000;
         5'd8:    p = 65'd100000000;
         5'd9:    p = 65'd1000000000;
         5'd10:   p = 65'd10000000000;
         5'd11:   p = 65'd100000000000;
         5'd12:   p = 65'd1000000000000;
         5'd13:   p = 65'd10000000000000;
         5'd14:   p = 65'd100000000000000;
         5'd15:   p = 65'd1000000000000000;
         5'd16:   p = 65'd10000000000000000;
         default: p = 65'd1;
      endcase
      return p;
   endfunction

   // Denominator of the fraction: radix raised to the number of kept digits.
   function automatic logic [DEN_W-1:0] frac_den(input logic [4:0] radix,
                                                 input logic [COUNT_W-1:0] n);
      logic [6:0]       sh;
      logic [DEN_W-1:0] p;
      case (radix)
         RADIX_BIN: sh = {2'b00, n};
         RADIX_OCT: sh = ({2'b00, n} << 1) + {2'b00, n};
         default:   sh = {n, 2'b00};
      endcase
      if (radix == RADIX_DEC) begin
         p = pow10(n);
      end else begin
         p = DEN_W'(1) << sh;
      end
      return p;
   endfunction

endpackage

@@ rtl/rlp_scan.sv @@
module rlp_scan #(
   parameter int INT_BITS        = rlp_pkg::DEF_INT_BITS,
   parameter int MAX_FRAC_DIGITS = rlp_pkg::DEF_MAX_FRAC_DIGITS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            take_char,
   input  logic                            take_end,
   input  logic [7:0]                      character,
   output rlp_pkg::rlp_summary_type        summary,
   output logic [INT_BITS-1:0]             acc,
   output logic [rlp_pkg::NUM_W-1:0]       num
);

   localparam int AW = INT_BITS + 5;

   typedef enum logic [2:0] {
      PH_START,
      PH_ZERO,
      PH_INT,
      PH_FRAC,
      PH_ERR
   } phase_type;

   phase_type                       phase_ff, phase_in;
   logic [4:0]                      radix_ff, radix_in;
   logic [INT_BITS-1:0]             acc_ff, acc_in;
   logic [rlp_pkg::NUM_W-1:0]       num_ff, num_in;
   logic [rlp_pkg::COUNT_W-1:0]     count_ff, count_in;
   logic [2:0]                      status_ff, status_in;

   logic                            body_en;
   logic                            in_frac;
   logic [4:0]                      dig;
   logic [AW-1:0]                   acc_ext;
   logic [AW-1:0]                   acc_scaled;
   logic [AW-1:0]                   acc_sum;
   logic [rlp_pkg::NUM_W-1:0]       num_scaled;
   logic [rlp_pkg::NUM_W-1:0]       num_sum;

   assign dig     = rlp_pkg::digit_of(character, radix_ff);
   assign in_frac = (phase_ff == PH_FRAC);
   assign acc_ext = AW'(acc_ff);

   // Multiplication by the radix is a shift, or two shifts and an add for decimal.
   always_comb begin
      case (radix_ff)
         rlp_pkg::RADIX_BIN: begin
            acc_scaled = acc_ext << 1;
            num_scaled = num_ff << 1;
         end
         rlp_pkg::RADIX_OCT: begin
            acc_scaled = acc_ext << 3;
            num_scaled = num_ff << 3;
         end
         rlp_pkg::RADIX_HEX: begin
            acc_scaled = acc_ext << 4;
            num_scaled = num_ff << 4;
         end
         default: begin
            acc_scaled = (acc_ext << 3) + (acc_ext << 1);
            num_scaled = (num_ff << 3) + (num_ff << 1);
         end
      endcase
   end

   assign acc_sum = acc_scaled + AW'(dig[3:0]);
   assign num_sum = num_scaled + rlp_pkg::NUM_W'(dig[3:0]);

   always_comb begin
      phase_in  = phase_ff;
      radix_in  = radix_ff;
      acc_in    = acc_ff;
      num_in    = num_ff;
      count_in  = count_ff;
      status_in = status_ff;
      body_en   = 1'b0;
      if (take_end) begin
         phase_in  = PH_START;
         radix_in  = rlp_pkg::RADIX_NONE;
         acc_in    = '0;
         num_in    = '0;
         count_in  = '0;
         status_in = rlp_pkg::ST_OK;
      end else if (take_char) begin
         case (phase_ff)
            PH_START: begin
               if (character == rlp_pkg::CHAR_0) begin
                  phase_in = PH_ZERO;
                  radix_in = rlp_pkg::RADIX_OCT;
               end else if (character inside {[rlp_pkg::CHAR_1:rlp_pkg::CHAR_9]}) begin
                  phase_in = PH_INT;
                  radix_in = rlp_pkg::RADIX_DEC;
                  acc_in   = INT_BITS'(character[3:0]);
               end else begin
                  phase_in  = PH_ERR;
                  status_in = rlp_pkg::ST_BAD_PREFIX;
               end
            end
            PH_ZERO: begin
               phase_in = PH_INT;
               if (character == rlp_pkg::CHAR_B_LO || character == rlp_pkg::CHAR_B_UP) begin
                  radix_in = rlp_pkg::RADIX_BIN;
               end else if (character == rlp_pkg::CHAR_X_LO ||
                            character == rlp_pkg::CHAR_X_UP) begin
                  radix_in = rlp_pkg::RADIX_HEX;
               end else begin
                  body_en = 1'b1;
               end
            end
            PH_INT, PH_FRAC: body_en = 1'b1;
            default: ;
         endcase

         if (body_en) begin
            if (character == rlp_pkg::CHAR_POINT) begin
               if (in_frac) begin
                  phase_in  = PH_ERR;
                  status_in = rlp_pkg::bad_code(radix_ff);
               end else begin
                  phase_in = PH_FRAC;
               end
            end else if (!dig[4]) begin
               phase_in  = PH_ERR;
               status_in = rlp_pkg::bad_code(radix_ff);
            end else if (!in_frac) begin
               // Once saturated, the integer holds its largest value.
               if (status_ff != rlp_pkg::ST_SATURATED) begin
                  if (|acc_sum[AW-1:INT_BITS]) begin
                     acc_in    = '1;
                     status_in = rlp_pkg::ST_SATURATED;
                  end else begin
                     acc_in = acc_sum[INT_BITS-1:0];
                  end
               end
            end else if (count_ff < rlp_pkg::COUNT_W'(MAX_FRAC_DIGITS)) begin
               num_in   = num_sum;
               count_in = count_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_START;
         radix_ff  <= rlp_pkg::RADIX_NONE;
         acc_ff    <= '0;
         num_ff    <= '0;
         count_ff  <= '0;
         status_ff <= rlp_pkg::ST_OK;
      end else begin
         phase_ff  <= phase_in;
         radix_ff  <= radix_in;
         acc_ff    <= acc_in;
         num_ff    <= num_in;
         count_ff  <= count_in;
         status_ff <= status_in;
      end
   end

   // Outside the error phase the pending status is either ok or saturated; in the start phase bad prefix is reported.
   always_comb begin
      summary.radix      = radix_ff;
      summary.frac_count = count_ff;
      case (phase_ff)
         PH_START: summary.status = rlp_pkg::ST_BAD_PREFIX;
         default:  summary.status = status_ff;
      endcase
   end

   assign acc = acc_ff;
   assign num = num_ff;

endmodule

@@ rtl/rlp_frac_div.sv @@
module rlp_frac_div #(
   parameter int FRAC_BITS = rlp_pkg::DEF_FRAC_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [rlp_pkg::NUM_W-1:0]         num,
   input  logic [4:0]                        radix,
   input  logic [rlp_pkg::COUNT_W-1:0]       frac_count,
   output logic                              done,
   output logic [FRAC_BITS-1:0]              quotient
);

   localparam int CW = $clog2(FRAC_BITS);

   logic                          busy_ff, busy_in;
   logic [CW-1:0]                 cnt_ff, cnt_in;
   logic [rlp_pkg::DEN_W-1:0]     rem_ff, rem_in;
   logic [rlp_pkg::DEN_W-1:0]     den_ff, den_in;
   logic [FRAC_BITS-1:0]          quo_ff, quo_in;

   logic [rlp_pkg::DEN_W-1:0]     rem_sh;
   logic                          fits;

   // Restoring division, one quotient bit per cycle. The numerator is always
   // below the denominator, so the remainder shifted left never overflows.
   assign rem_sh = {rem_ff[rlp_pkg::DEN_W-2:0], 1'b0};
   assign fits   = (rem_sh >= den_ff);
   assign done   = busy_ff && (cnt_ff == '0);

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(FRAC_BITS - 1);
         rem_in  = rlp_pkg::DEN_W'(num);
         den_in  = rlp_pkg::frac_den(radix, frac_count);
      end else if (busy_ff) begin
         rem_in = fits ? (rem_sh - den_ff) : rem_sh;
         quo_in = {quo_ff[FRAC_BITS-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign quotient = quo_ff;

endmodule

@@ rtl/radix_literal_parser.sv @@
// Characters are taken one per cycle while idle, with no result; an end transfer starts
// the fraction divider, which makes one quotient bit per cycle.
// The result is registered from the drain state once the divider is done, and the next input
// is taken when the parser is back in idle, later while the output register stays full.
// Synchronous active-high reset returns the scanner to the start of a literal,
// stops the divider and empties the output register.
module radix_literal_parser #(
   parameter int INT_BITS        = rlp_pkg::DEF_INT_BITS,
   parameter int FRAC_BITS       = rlp_pkg::DEF_FRAC_BITS,
   parameter int MAX_FRAC_DIGITS = rlp_pkg::DEF_MAX_FRAC_DIGITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  rlp_pkg::rlp_req_type  req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rlp_pkg::rlp_rsp_type  rsp_payload
);

   localparam int VW = INT_BITS + FRAC_BITS;

   typedef enum logic [1:0] {
      S_IDLE,
      S_CALC,
      S_DRAIN
   } state_type;

   state_type                     state_ff, state_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   rlp_pkg::rlp_rsp_type          rsp_payload_ff, rsp_payload_in;
   logic [INT_BITS-1:0]           ctx_acc_ff, ctx_acc_in;
   logic [2:0]                    ctx_status_ff, ctx_status_in;

   logic                          take;
   logic                          take_char;
   logic                          take_end;
   rlp_pkg::rlp_summary_type      summary;
   logic [INT_BITS-1:0]           acc;
   logic [rlp_pkg::NUM_W-1:0]     num;
   logic                          div_done;
   logic [FRAC_BITS-1:0]          quotient;
   logic                          out_free;

   assign req_ready = (state_ff == S_IDLE);
   assign take      = req_valid && req_ready;
   assign take_char = take && !req_payload.end_of_literal;
   assign take_end  = take && req_payload.end_of_literal;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   rlp_scan #(
      .INT_BITS        (INT_BITS),
      .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .take_char (take_char),
      .take_end  (take_end),
      .character (req_payload.character),
      .summary   (summary),
      .acc       (acc),
      .num       (num)
   );

   rlp_frac_div #(
      .FRAC_BITS (FRAC_BITS)
   ) u_frac_div (
      .clock      (clock),
      .reset      (reset),
      .start      (take_end),
      .num        (num),
      .radix      (summary.radix),
      .frac_count (summary.frac_count),
      .done       (div_done),
      .quotient   (quotient)
   );

   always_comb begin
      state_in       = state_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_payload_in = rsp_payload_ff;
      ctx_acc_in     = ctx_acc_ff;
      ctx_status_in  = ctx_status_ff;
      case (state_ff)
         S_IDLE: begin
            if (take_end) begin
               ctx_acc_in    = acc;
               ctx_status_in = summary.status;
               state_in      = S_CALC;
            end
         end
         S_CALC: begin
            if (div_done) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_payload_in.status = ctx_status_ff;
               case (ctx_status_ff)
                  rlp_pkg::ST_OK:
                     rsp_payload_in.value = 64'({ctx_acc_ff, quotient});
                  rlp_pkg::ST_SATURATED:
                     rsp_payload_in.value = 64'({VW{1'b1}});
                  default:
                     rsp_payload_in.value = '0;
               endcase
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_payload_ff <= rsp_payload_in;
      ctx_acc_ff     <= ctx_acc_in;
      ctx_status_ff  <= ctx_status_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // An end transfer always starts a fraction computation.
   a_end_starts_calc : assert property (@(posedge clock) disable iff (reset)
      take_end |=> (state_ff == S_CALC))
      else $error("end transfer did not start the divider");

   // A new result only appears out of the drain state.
   a_result_from_drain : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> ($past(state_ff) == S_DRAIN))
      else $error("result appeared outside the drain state");

   // Error results carry a zero value.
   a_error_value_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.status != rlp_pkg::ST_OK &&
       rsp_payload.status != rlp_pkg::ST_SATURATED) |-> (rsp_payload.value == '0))
      else $error("error result with nonzero value");

   // A saturated result has every fraction bit set.
   a_saturated_fraction : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.status == rlp_pkg::ST_SATURATED) |->
         (&rsp_payload.value[FRAC_BITS-1:0]))
      else $error("saturated result with fraction bits clear");

endmodule

@@ dv/tb_radix_literal_parser.sv @@
`timescale 1ns / 1ps

module tb_radix_literal_parser;

   localparam int INT_BITS        = rlp_pkg::DEF_INT_BITS;
   localparam int FRAC_BITS       = rlp_pkg::DEF_FRAC_BITS;
   localparam int MAX_FRAC_DIGITS = rlp_pkg::DEF_MAX_FRAC_DIGITS;
   localparam int STIMULUS_ITEMS  = 1300;
   localparam int WATCHDOG_LIMIT  = 5000;

   localparam logic [63:0] INT_LIMIT  = (64'd1 << INT_BITS) - 64'd1;
   localparam logic [63:0] FRAC_ONES  = (64'd1 << FRAC_BITS) - 64'd1;
   localparam logic [63:0] FULL_SCALE = (INT_LIMIT << FRAC_BITS) | FRAC_ONES;

   typedef enum logic [2:0] {
      SCAN_START,
      SCAN_ZERO,
      SCAN_INT,
      SCAN_FRAC,
      SCAN_ERR
   } scan_phase_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   rlp_pkg::rlp_req_type req_payload = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rlp_pkg::rlp_rsp_type rsp_payload;

   radix_literal_parser DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   rlp_pkg::rlp_req_type char_stream[$];
   rlp_pkg::rlp_rsp_type expected_results[$];
   rlp_pkg::rlp_rsp_type wanted;
   int                   failures = 0;

   // Scanner state of the predictor.
   scan_phase_type scan_phase = SCAN_START;
   logic [4:0]     scan_radix = rlp_pkg::RADIX_NONE;
   logic [63:0]    int_acc = '0;
   logic [63:0]    frac_num = '0;
   int             frac_count = 0;
   logic [2:0]     held_status = rlp_pkg::ST_OK;

   function automatic int digit_value(input logic [7:0] c, input logic [4:0] r);
      int ci;
      ci = int'(c);
      if (r == rlp_pkg::RADIX_HEX && ci >= int'(rlp_pkg::CHAR_A) &&
          ci <= int'(rlp_pkg::CHAR_F)) begin
         return ci - int'(rlp_pkg::CHAR_A) + 10;
      end
      if (ci >= int'(rlp_pkg::CHAR_0) && ci <= int'(rlp_pkg::CHAR_9) &&
          ci - int'(rlp_pkg::CHAR_0) < int'(r)) begin
         return ci - int'(rlp_pkg::CHAR_0);
      end
      return -1;
   endfunction

   function automatic logic [2:0] bad_digit_status(input logic [4:0] r);
      case (r)
         rlp_pkg::RADIX_BIN: return rlp_pkg::ST_BAD_BIN;
         rlp_pkg::RADIX_HEX: return rlp_pkg::ST_BAD_HEX;
         rlp_pkg::RADIX_OCT: return rlp_pkg::ST_BAD_OCT;
         default:            return rlp_pkg::ST_BAD_DEC;
      endcase
   endfunction

   // Truncated binary fraction of num / radix^count.
   function automatic logic [63:0] fraction_field(input logic [4:0] r, input int count,
                                                  input logic [63:0] num);
      logic [63:0] den;
      logic [63:0] rem;
      logic [63:0] quo;
      int          bits_per_digit;
      int          total;
      if (count == 0) return '0;
      if (r == rlp_pkg::RADIX_DEC) begin
         den = 64'd1;
         for (int i = 0; i < count; i++) den = den * 64'd10;
         rem = num;
         quo = '0;
         for (int i = 0; i < FRAC_BITS; i++) begin
            rem = rem << 1;
            quo = quo << 1;
            if (rem >= den) begin
               quo[0] = 1'b1;
               rem = rem - den;
            end
         end
         return quo;
      end
      bits_per_digit = (r == rlp_pkg::RADIX_BIN) ? 1 : (r == rlp_pkg::RADIX_OCT) ? 3 : 4;
      total = bits_per_digit * count;
      if (total >= FRAC_BITS) return num >> (total - FRAC_BITS);
      return num << (FRAC_BITS - total);
   endfunction

   task automatic clear_scanner();
      scan_phase  = SCAN_START;
      scan_radix  = rlp_pkg::RADIX_NONE;
      int_acc     = '0;
      frac_num    = '0;
      frac_count  = 0;
      held_status = rlp_pkg::ST_OK;
   endtask

   task automatic reject(input logic [2:0] code);
      held_status = code;
      scan_phase  = SCAN_ERR;
   endtask

   task automatic scan_body(input logic [7:0] c);
      int          d;
      logic [63:0] grown;
      d = digit_value(c, scan_radix);
      if (c == rlp_pkg::CHAR_POINT) begin
         if (scan_phase == SCAN_FRAC) reject(bad_digit_status(scan_radix));
         else scan_phase = SCAN_FRAC;
      end else if (d < 0) begin
         reject(bad_digit_status(scan_radix));
      end else if (scan_phase == SCAN_INT) begin
         // Once saturated, further integer digits are only checked.
         if (held_status != rlp_pkg::ST_SATURATED) begin
            grown = int_acc * 64'(scan_radix) + 64'(d);
            if (grown > INT_LIMIT) begin
               int_acc     = INT_LIMIT;
               held_status = rlp_pkg::ST_SATURATED;
            end else begin
               int_acc = grown;
            end
         end
      end else if (frac_count < MAX_FRAC_DIGITS) begin
         frac_num   = frac_num * 64'(scan_radix) + 64'(d);
         frac_count = frac_count + 1;
      end
   endtask

   // Advances the predicted scanner by one accepted transfer.
   task automatic literal_step(input rlp_pkg::rlp_req_type item);
      rlp_pkg::rlp_rsp_type res;
      if (item.end_of_literal) begin
         res.value = '0;
         if (scan_phase == SCAN_START) begin
            res.status = rlp_pkg::ST_BAD_PREFIX;
         end else if (scan_phase == SCAN_ERR) begin
            res.status = held_status;
         end else if (held_status == rlp_pkg::ST_SATURATED) begin
            res.status = rlp_pkg::ST_SATURATED;
            res.value  = FULL_SCALE;
         end else begin
            res.status = rlp_pkg::ST_OK;
            res.value  = (int_acc << FRAC_BITS) |
                         fraction_field(scan_radix, frac_count, frac_num);
         end
         expected_results.push_back(res);
         clear_scanner();
      end else begin
         case (scan_phase)
            SCAN_START: begin
               if (item.character == rlp_pkg::CHAR_0) begin
                  scan_phase = SCAN_ZERO;
                  scan_radix = rlp_pkg::RADIX_OCT;
               end else if (item.character >= rlp_pkg::CHAR_1 &&
                            item.character <= rlp_pkg::CHAR_9) begin
                  scan_radix = rlp_pkg::RADIX_DEC;
                  scan_phase = SCAN_INT;
                  scan_body(item.character);
               end else begin
                  reject(rlp_pkg::ST_BAD_PREFIX);
               end
            end
            SCAN_ZERO: begin
               if (item.character == rlp_pkg::CHAR_B_UP ||
                   item.character == rlp_pkg::CHAR_B_LO) begin
                  scan_radix = rlp_pkg::RADIX_BIN;
                  scan_phase = SCAN_INT;
               end else if (item.character == rlp_pkg::CHAR_X_UP ||
                            item.character == rlp_pkg::CHAR_X_LO) begin
                  scan_radix = rlp_pkg::RADIX_HEX;
                  scan_phase = SCAN_INT;
               end else begin
                  scan_phase = SCAN_INT;
                  scan_body(item.character);
               end
            end
            SCAN_INT, SCAN_FRAC: scan_body(item.character);
            default: ;
         endcase
      end
   endtask

   task automatic queue_char(input logic [7:0] c);
      rlp_pkg::rlp_req_type t;
      t.character      = c;
      t.end_of_literal = 1'b0;
      char_stream.push_back(t);
   endtask

   // The character field of an end transfer is ignored, so it carries noise.
   task automatic queue_end();
      rlp_pkg::rlp_req_type t;
      t.character      = 8'($urandom_range(0, 255));
      t.end_of_literal = 1'b1;
      char_stream.push_back(t);
   endtask

   task automatic queue_literal(input string text);
      for (int i = 0; i < text.len(); i++) queue_char(text[i]);
      queue_end();
   endtask

   function automatic logic [7:0] random_digit(input logic [4:0] r);
      int d;
      d = $urandom_range(0, int'(r) - 1);
      if (d < 10) return rlp_pkg::CHAR_0 + 8'(d);
      return rlp_pkg::CHAR_A + 8'(d - 10);
   endfunction

   task automatic queue_random_literal();
      logic [7:0] chars[$];
      logic [4:0] r;
      logic [7:0] bad;
      int         pick;
      int         n_int;
      int         n_frac;
      int         pos;
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
         repeat ($urandom_range(0, 6)) chars.push_back(8'($urandom_range(0, 255)));
      end else begin
         case ($urandom_range(0, 3))
            0: begin
               r = rlp_pkg::RADIX_BIN;
               chars.push_back(rlp_pkg::CHAR_0);
               chars.push_back($urandom_range(0, 1) ? rlp_pkg::CHAR_B_UP
                                                    : rlp_pkg::CHAR_B_LO);
            end
            1: begin
               r = rlp_pkg::RADIX_OCT;
               chars.push_back(rlp_pkg::CHAR_0);
            end
            2: r = rlp_pkg::RADIX_DEC;
            default: begin
               r = rlp_pkg::RADIX_HEX;
               chars.push_back(rlp_pkg::CHAR_0);
               chars.push_back($urandom_range(0, 1) ? rlp_pkg::CHAR_X_UP
                                                    : rlp_pkg::CHAR_X_LO);
            end
         endcase
         // A few long integer parts drive the accumulator into saturation.
         n_int = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 10);
         if (r == rlp_pkg::RADIX_DEC) begin
            chars.push_back(rlp_pkg::CHAR_0 + 8'($urandom_range(1, 9)));
            n_int = (n_int > 0) ? n_int - 1 : 0;
         end
         repeat (n_int) chars.push_back(random_digit(r));
         if ($urandom_range(0, 2) != 0) begin
            chars.push_back(rlp_pkg::CHAR_POINT);
            n_frac = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 22) : $urandom_range(0, 8);
            repeat (n_frac) chars.push_back(random_digit(r));
         end
         if (pick < 28) begin
            pos = $urandom_range(0, chars.size());
            bad = $urandom_range(0, 1) ? 8'($urandom_range(0, 255))
                                       : 8'($urandom_range(int'(rlp_pkg::CHAR_POINT), 8'h66));
            case ($urandom_range(0, 2))
               0: chars.insert(pos, rlp_pkg::CHAR_POINT);
               1: chars.insert(pos, bad);
               default: begin
                  if (pos < chars.size()) chars[pos] = bad;
                  else chars.push_back(bad);
               end
            endcase
         end
      end
      foreach (chars[i]) queue_char(chars[i]);
      queue_end();
   endtask

   // Sender: bursts of back-to-back transfers separated by random gaps.
   int burst_left = 0;
   int gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid   <= 1'b0;
         req_payload <= '0;
         burst_left  <= 0;
         gap_left    <= 0;
      end else if (!req_valid || req_ready) begin
         if (gap_left > 0) begin
            gap_left  <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (char_stream.size() > 0) begin
            req_valid   <= 1'b1;
            req_payload <= char_stream.pop_front();
            if (burst_left > 1) begin
               burst_left <= burst_left - 1;
            end else begin
               burst_left <= $urandom_range(1, 24);
               gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: cycles through always ready, even stalls, heavy stalls and a
   // fixed periodic pattern.
   logic [9:0] stall_cycle = '0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready   <= 1'b0;
         stall_cycle <= '0;
      end else begin
         stall_cycle <= stall_cycle + 10'd1;
         case (stall_cycle[9:8])
            2'd0:    rsp_ready <= 1'b1;
            2'd1:    rsp_ready <= ($urandom_range(0, 1) == 1);
            2'd2:    rsp_ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ready <= (stall_cycle[2:0] != 3'd0);
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) literal_step(req_payload);
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result transfer, value %h status %0d",
                        $time, rsp_payload.value, rsp_payload.status);
               failures++;
            end else begin
               wanted = expected_results.pop_front();
               if (rsp_payload.value !== wanted.value) begin
                  $display("%0t: value mismatch: expected %h, actual %h",
                           $time, wanted.value, rsp_payload.value);
                  failures++;
               end
               if (rsp_payload.status !== wanted.status) begin
                  $display("%0t: status mismatch: expected %0d, actual %0d",
                           $time, wanted.status, rsp_payload.status);
                  failures++;
               end
            end
         end
      end
   end

   int stalled_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stalled_cycles <= 0;
      end else if (stalled_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         stalled_cycles <= stalled_cycles + 1;
      end
   end

   initial begin
      // Directed literals: prefixes, bad digits, saturation, long fractions.
      queue_end();
      queue_literal("g");
      queue_literal("0");
      queue_literal("0b");
      queue_literal("0x");
      queue_literal("0.");
      queue_literal("09");
      queue_literal("0b101.11");
      queue_literal("0B2");
      queue_literal("0xFF.8");
      queue_literal("0Xa");
      queue_literal("017.4");
      queue_literal("018");
      queue_literal("123.456");
      queue_literal("1.2.3");
      queue_literal("4294967295");
      queue_literal("4294967296");
      queue_literal("99999999999.5");
      queue_literal("99999999999z");
      queue_literal("0.12345678901234567890");
      queue_literal("0x.FFFFFFFFFFFFFFFFFFFF");
      queue_literal("0b.11111111111111111111");
      queue_literal("9.9999999999999999");
      queue_literal("0xFFFFFFFF.FFFFFFFF");
      while (char_stream.size() < STIMULUS_ITEMS) queue_random_literal();

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Sample at the falling edge so that all updates of the rising edge are visible.
      while (char_stream.size() != 0 || req_valid) @(negedge clock);
      while (expected_results.size() != 0) @(negedge clock);
      repeat (FRAC_BITS + 8) @(negedge clock);
      if (failures == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

@@ radix_literal_parser.f @@
rtl/rlp_pkg.sv
rtl/rlp_scan.sv
rtl/rlp_frac_div.sv
rtl/radix_literal_parser.sv
dv/tb_radix_literal_parser.sv
